// File: sv/b2d_pkg.sv
// ----------------------------------------------------------------------------
// b2d_pkg
// Shared constants, types and helpers for the binary to decimal digit block.
// ----------------------------------------------------------------------------
package b2d_pkg;

   localparam int VALUE_WIDTH = 128;
   localparam int HALF_WIDTH  = 64;
   // decimal digits needed for the widest value: floor(w * log10(2)) + 1
   localparam int DIGITS      = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int BCD_WIDTH   = 4 * DIGITS;
   localparam int CNT_W       = $clog2(VALUE_WIDTH);
   localparam int IDX_W       = $clog2(DIGITS);
   localparam int CAP_W       = 8;
   localparam int WR_W        = 6;
   localparam int DIGIT_W     = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam logic [CSR_ADDR_W-1:0] REG_CAPACITY = 3'd0;
   localparam logic [CAP_W-1:0]      CAPACITY_RST = 8'd40;
   localparam logic [CAP_W-1:0]      CAP_MIN      = 8'd2;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic                   empty;  // capacity below two: no digit at all
      logic [CAP_W-1:0]       limit;  // capacity minus one
   } item_type;

   // add three to every BCD digit of five or more
   function automatic logic [BCD_WIDTH-1:0] dabble_adj(input logic [BCD_WIDTH-1:0] bcd);
      logic [BCD_WIDTH-1:0] res;
      res = bcd;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd[4*i +: 4] >= 4'd5) begin
            res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
         end
      end
      return res;
   endfunction

endpackage

// File: sv/b2d_front.sv
// ----------------------------------------------------------------------------
// b2d_front
// Accepts values, classifies them against capacity and queues them.
// ----------------------------------------------------------------------------
module b2d_front
   import b2d_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [HALF_WIDTH-1:0] req_value_low,
   input  logic [HALF_WIDTH-1:0] req_value_high,
   input  logic [CAP_W-1:0]      capacity,
   output logic                  item_valid,
   input  logic                  item_pop,
   output item_type              item
);

   item_type                  queue_ff [2];
   logic                      wr_ptr_ff, wr_ptr_in;
   logic                      rd_ptr_ff, rd_ptr_in;
   logic [1:0]                count_ff, count_in;
   logic [2*HALF_WIDTH-1:0]   full_value;
   item_type                  new_item;
   logic                      push;
   logic                      pop;

   assign full_value = {req_value_high, req_value_low};

   always_comb begin
      new_item.value = full_value[VALUE_WIDTH-1:0];
      new_item.empty = (capacity < CAP_MIN);
      new_item.limit = capacity - 8'd1;
   end

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign item_valid = (count_ff != 2'd0);
   assign pop        = item_pop && item_valid;
   assign item       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// File: sv/b2d_back.sv
// ----------------------------------------------------------------------------
// b2d_back
// Bit-serial double dabble, leading zero skip and digit emission.
// ----------------------------------------------------------------------------
module b2d_back
   import b2d_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   output logic               item_pop,
   input  item_type           item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [DIGIT_W-1:0] rsp_digit,
   output logic               rsp_last,
   output logic [WR_W-1:0]    rsp_written,
   output logic               rsp_empty_res
);

   typedef enum logic [1:0] {IDLE, CONV, SKIP, EMIT} state_type;

   state_type               state_ff, state_in;
   logic [VALUE_WIDTH-1:0]  shv_ff, shv_in;
   logic [BCD_WIDTH-1:0]    bcd_ff, bcd_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [WR_W-1:0]         emitted_ff, emitted_in;
   logic [CAP_W-1:0]        limit_ff, limit_in;
   logic                    empty_ff, empty_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DIGIT_W-1:0]      rsp_digit_ff, rsp_digit_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [WR_W-1:0]         rsp_written_ff, rsp_written_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   logic                    out_free;
   logic [BCD_WIDTH-1:0]    bcd_adj;
   logic [DIGIT_W-1:0]      top_digit;
   logic [WR_W-1:0]         emitted_inc;
   logic                    fin;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign item_pop    = (state_ff == IDLE) && item_valid;
   assign bcd_adj     = dabble_adj(bcd_ff);
   assign top_digit   = bcd_ff[BCD_WIDTH-1 -: DIGIT_W];
   assign emitted_inc = emitted_ff + 6'd1;
   assign fin         = (idx_ff == '0) || ({2'b00, emitted_inc} == limit_ff);

   always_comb begin
      state_in       = state_ff;
      shv_in         = shv_ff;
      bcd_in         = bcd_ff;
      cnt_in         = cnt_ff;
      idx_in         = idx_ff;
      emitted_in     = emitted_ff;
      limit_in       = limit_ff;
      empty_in       = empty_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_digit_in   = rsp_digit_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_written_in = rsp_written_ff;
      rsp_empty_in   = rsp_empty_ff;
      case (state_ff)
         IDLE: begin
            if (item_valid) begin
               shv_in     = item.value;
               bcd_in     = '0;
               cnt_in     = CNT_W'(VALUE_WIDTH - 1);
               limit_in   = item.limit;
               empty_in   = item.empty;
               emitted_in = '0;
               state_in   = item.empty ? EMIT : CONV;
            end
         end
         CONV: begin
            bcd_in = {bcd_adj[BCD_WIDTH-2:0], shv_ff[VALUE_WIDTH-1]};
            shv_in = {shv_ff[VALUE_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               idx_in   = IDX_W'(DIGITS - 1);
               state_in = SKIP;
            end
         end
         SKIP: begin
            // drop leading zero digits, keep at least one
            if (top_digit == '0 && idx_ff != '0) begin
               bcd_in = {bcd_ff[BCD_WIDTH-5:0], 4'd0};
               idx_in = idx_ff - IDX_W'(1);
            end else begin
               state_in = EMIT;
            end
         end
         EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (empty_ff) begin
                  rsp_digit_in   = '0;
                  rsp_last_in    = 1'b1;
                  rsp_written_in = '0;
                  rsp_empty_in   = 1'b1;
                  state_in       = IDLE;
               end else begin
                  rsp_digit_in   = top_digit;
                  rsp_last_in    = fin;
                  rsp_written_in = fin ? emitted_inc : '0;
                  rsp_empty_in   = 1'b0;
                  bcd_in         = {bcd_ff[BCD_WIDTH-5:0], 4'd0};
                  idx_in         = idx_ff - IDX_W'(1);
                  emitted_in     = emitted_inc;
                  if (fin) begin
                     state_in = IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      shv_ff         <= shv_in;
      bcd_ff         <= bcd_in;
      cnt_ff         <= cnt_in;
      idx_ff         <= idx_in;
      emitted_ff     <= emitted_in;
      limit_ff       <= limit_in;
      empty_ff       <= empty_in;
      rsp_digit_ff   <= rsp_digit_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_written_ff <= rsp_written_in;
      rsp_empty_ff   <= rsp_empty_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_digit     = rsp_digit_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_written   = rsp_written_ff;
   assign rsp_empty_res = rsp_empty_ff;

`ifndef ASSERT_OFF
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |-> rsp_last_ff && rsp_written_ff == '0)
      else $error("empty result not final or has a count");

   a_last_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff && !rsp_empty_ff |-> rsp_written_ff != '0)
      else $error("final digit carries zero count");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_digit_ff <= 4'd9)
      else $error("digit out of decimal range");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> state_ff == IDLE && rsp_valid_in == (rsp_valid_ff && rsp_stall))
      else $error("item taken while busy");
`endif

endmodule

// File: sv/binary128_to_decimal_digits.sv
// ----------------------------------------------------------------------------
// binary128_to_decimal_digits
// Converts a 128-bit unsigned value into its decimal digits, MSD first.
// ----------------------------------------------------------------------------
// Usage: the request channel takes one 128-bit value as two 64-bit halves per
// beat (req_valid / req_stall). The response channel returns one beat per
// decimal digit, most significant first, with rsp_last on the final beat and
// rsp_written giving the digit count there. A zero value yields one digit 0.
// At most capacity-1 digits are sent; capacity below two yields one beat with
// rsp_empty_res set and no digit. capacity sits at byte address 0 of the
// APB-style port and is sampled when a value is accepted.
// Timing: a two-entry queue holds accepted values. Each value is loaded, run
// through bit-serial double dabble, stripped of leading zeros, then sent at
// one digit per cycle while the response is not stalled; an empty beat skips
// conversion and goes straight to emission.
// Reset clears the queue, the converter and the output register; capacity
// returns to 40. A stalled response beat holds, and the converter waits on it.
// ----------------------------------------------------------------------------
module binary128_to_decimal_digits
   import b2d_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [HALF_WIDTH-1:0] req_value_low,
   input  logic [HALF_WIDTH-1:0] req_value_high,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DIGIT_W-1:0]    rsp_digit,
   output logic                  rsp_last,
   output logic [WR_W-1:0]       rsp_written,
   output logic                  rsp_empty_res,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic             cap_sel;
   logic             item_valid;
   logic             item_pop;
   item_type         item;

   assign pready  = 1'b1;
   assign cap_sel = (paddr[CSR_ADDR_W-1:2] == REG_CAPACITY[CSR_ADDR_W-1:2]);
   assign prdata  = cap_sel ? {{(CSR_DATA_W-CAP_W){1'b0}}, capacity_ff} : '0;

   always_comb begin
      capacity_in = capacity_ff;
      if (psel && penable && pwrite && pready && cap_sel) begin
         capacity_in = pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RST;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   b2d_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value_low  (req_value_low),
      .req_value_high (req_value_high),
      .capacity       (capacity_ff),
      .item_valid     (item_valid),
      .item_pop       (item_pop),
      .item           (item)
   );

   b2d_back u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (item_valid),
      .item_pop      (item_pop),
      .item          (item),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_digit     (rsp_digit),
      .rsp_last      (rsp_last),
      .rsp_written   (rsp_written),
      .rsp_empty_res (rsp_empty_res)
   );

endmodule

// File: test/tb_binary128_to_decimal_digits.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary128_to_decimal_digits
// Self-checking bench for the 128-bit binary to decimal digit converter.
// Values go in on the request channel; every digit beat that comes back is
// compared with a digit list worked out here by repeated division by ten,
// trimmed to capacity minus one. Capacity is changed between phases over the
// APB-style port and read back. Both channels idle in random bursts, the
// response side holds off once for a long stretch, and the last phase runs
// without idling.
// ----------------------------------------------------------------------------
module tb_binary128_to_decimal_digits;
   import b2d_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] REG_UNUSED = 3'd4;  // register index one: no register
   localparam int LONG_HOLD     = 3000;
   localparam int TAIL_CYCLES   = 256;
   localparam int PHASE_ITEMS   = 43;
   localparam int PRINT_LIMIT   = 50;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic               last;
      logic [WR_W-1:0]    written;
      logic               empty;
   } digit_beat_type;

   logic                  clock;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic [HALF_WIDTH-1:0] req_value_low  = '0;
   logic [HALF_WIDTH-1:0] req_value_high = '0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic [DIGIT_W-1:0]    rsp_digit;
   logic                  rsp_last;
   logic [WR_W-1:0]       rsp_written;
   logic                  rsp_empty_res;
   logic                  psel           = 1'b0;
   logic                  penable        = 1'b0;
   logic                  pwrite         = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr          = '0;
   logic [CSR_DATA_W-1:0] pwdata         = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   logic [2*HALF_WIDTH-1:0] value_pending[$];
   digit_beat_type          digit_expect[$];
   logic [CAP_W-1:0]        capacity_model = CAPACITY_RST;

   bit quiet_tail        = 1'b0;
   bit long_hold_request = 1'b0;
   bit long_hold_taken   = 1'b0;
   bit beat_live         = 1'b0;
   int send_gap          = 0;
   int rsp_gap           = 0;
   int long_hold_left    = 0;
   int errors            = 0;
   int values_taken      = 0;
   int beats_seen        = 0;
   int empty_beats       = 0;
   int input_stalls      = 0;
   int capacity_writes   = 0;

   binary128_to_decimal_digits uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value_low  (req_value_low),
      .req_value_high (req_value_high),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit      (rsp_digit),
      .rsp_last       (rsp_last),
      .rsp_written    (rsp_written),
      .rsp_empty_res  (rsp_empty_res),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      errors++;
      if (errors <= PRINT_LIMIT) begin
         $display("MISMATCH %s: got %0d, expected %0d (beat %0d)", what, got, want, beats_seen);
      end
   endtask

   // digit list of one value, most significant first, cut to capacity - 1
   function automatic void predict_digits(input logic [HALF_WIDTH-1:0] lo,
                                          input logic [HALF_WIDTH-1:0] hi,
                                          input logic [CAP_W-1:0] cap);
      logic [VALUE_WIDTH-1:0] rest;
      logic [DIGIT_W-1:0]     rev [DIGITS];
      digit_beat_type         b;
      int                     n;
      int                     lim;
      rest = {hi, lo};
      n = 0;
      b = '0;
      if (cap < CAP_MIN) begin
         b.last = 1'b1;
         b.empty = 1'b1;
         digit_expect.push_back(b);
         return;
      end
      if (rest == '0) begin
         b.last = 1'b1;
         b.written = WR_W'(1);
         digit_expect.push_back(b);
         return;
      end
      while (rest != '0 && n < DIGITS) begin
         rev[n] = DIGIT_W'(rest % 10);
         rest = rest / 10;
         n++;
      end
      lim = int'(cap) - 1;
      if (lim > n) lim = n;
      for (int k = 0; k < lim; k++) begin
         b.digit = rev[n - 1 - k];
         b.last = (k == lim - 1);
         b.written = b.last ? WR_W'(lim) : '0;
         digit_expect.push_back(b);
      end
   endfunction

   function automatic logic [127:0] ten_to_the(input int k);
      logic [127:0] p;
      p = 128'd1;
      for (int i = 0; i < k; i++) p = p * 10;
      return p;
   endfunction

   function automatic logic [127:0] random_operand();
      logic [127:0] v;
      v = {$urandom(), $urandom(), $urandom(), $urandom()};
      case ($urandom_range(0, 7))
         0:       return v;
         1:       return 128'($urandom_range(0, 999));
         2:       return ten_to_the($urandom_range(0, 38));
         3:       return ten_to_the($urandom_range(1, 38)) - 1;
         4:       return $urandom_range(0, 1) ? '1 : '0;
         default: return v >> $urandom_range(0, 127);
      endcase
   endfunction

   // sender: offer pending values, idle in bursts
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_stall) input_stalls++;
         if (req_valid && !req_stall) begin
            predict_digits(req_value_low, req_value_high, capacity_model);
            values_taken++;
            beat_live = 1'b0;
         end
         if (!beat_live) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (value_pending.size() != 0) begin
               if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                  send_gap = $urandom_range(0, 15);
                  req_valid <= 1'b0;
               end else begin
                  {req_value_high, req_value_low} <= value_pending.pop_front();
                  req_valid <= 1'b1;
                  beat_live = 1'b1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stall bursts plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (long_hold_request && !long_hold_taken) begin
            long_hold_taken = 1'b1;
            long_hold_left = LONG_HOLD;
         end
         if (long_hold_left > 0) begin
            long_hold_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet_tail && rsp_gap > 0) begin
            rsp_gap--;
            rsp_stall <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_gap = $urandom_range(0, 15);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor: check each digit beat against the oldest expectation
   always @(posedge clock) begin
      digit_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_seen++;
         if (rsp_empty_res) empty_beats++;
         if (digit_expect.size() == 0) begin
            report_mismatch("unexpected digit beat, digit", rsp_digit, 0);
         end else begin
            want = digit_expect.pop_front();
            if (rsp_digit !== want.digit) report_mismatch("digit", rsp_digit, want.digit);
            if (rsp_last !== want.last) report_mismatch("last", rsp_last, want.last);
            if (rsp_written !== want.written)
               report_mismatch("written", rsp_written, want.written);
            if (rsp_empty_res !== want.empty)
               report_mismatch("empty_res", rsp_empty_res, want.empty);
         end
      end
   end

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (!wr && prdata !== {{(CSR_DATA_W-CAP_W){1'b0}}, capacity_model})
         report_mismatch("capacity readback", prdata, capacity_model);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // write then read back; only register index zero holds anything
   task automatic set_capacity(input logic [CSR_ADDR_W-1:0] addr,
                               input logic [CSR_DATA_W-1:0] data);
      csr_access(1'b1, addr, data);
      if (addr == REG_CAPACITY) begin
         capacity_model = data[CAP_W-1:0];
         capacity_writes++;
      end
      csr_access(1'b0, REG_CAPACITY, '0);
   endtask

   task automatic wait_drained();
      while (value_pending.size() != 0 || beat_live || digit_expect.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic run_random_phase(input logic [CAP_W-1:0] cap, input bit hold);
      set_capacity(REG_CAPACITY, {8'($urandom_range(0, 255)), 16'h0, cap});
      if (hold) long_hold_request = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) value_pending.push_back(random_operand());
      wait_drained();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset capacity: edges of the digit count, all ones and alternating bit patterns
      csr_access(1'b0, REG_CAPACITY, '0);
      value_pending.push_back(128'd0);
      value_pending.push_back(128'd1);
      value_pending.push_back(128'd9);
      value_pending.push_back(128'd10);
      value_pending.push_back(128'd99);
      value_pending.push_back(128'd100);
      value_pending.push_back({64'd0, {64{1'b1}}});
      value_pending.push_back({64'd1, 64'd0});
      value_pending.push_back(ten_to_the(19) - 1);
      value_pending.push_back(ten_to_the(19));
      value_pending.push_back(ten_to_the(38) - 1);
      value_pending.push_back(ten_to_the(38));
      value_pending.push_back('1);
      value_pending.push_back({32{4'h5}});
      value_pending.push_back({32{4'hA}});
      wait_drained();

      // capacity below two: one empty beat each
      set_capacity(REG_CAPACITY, 32'd0);
      value_pending.push_back(128'd0);
      value_pending.push_back('1);
      wait_drained();
      set_capacity(REG_CAPACITY, 32'd1);
      value_pending.push_back(128'd12345);
      wait_drained();

      // room for a single digit
      set_capacity(REG_CAPACITY, 32'd2);
      value_pending.push_back(128'd0);
      value_pending.push_back(128'd7);
      value_pending.push_back('1);
      wait_drained();

      // write to an empty register slot leaves capacity alone
      set_capacity(REG_UNUSED, 32'd5);
      value_pending.push_back(128'd98765);
      wait_drained();

      // widest capacity, junk in the upper data bits
      set_capacity(REG_CAPACITY, {24'hA5C3E1, 8'd255});
      value_pending.push_back('1);
      value_pending.push_back(ten_to_the(38));
      wait_drained();

      run_random_phase(8'd3, 1'b0);
      run_random_phase(8'd0, 1'b0);
      run_random_phase(8'd255, 1'b1);
      run_random_phase(8'd39, 1'b0);
      run_random_phase(8'd1, 1'b0);
      run_random_phase(8'd20, 1'b0);
      run_random_phase(8'($urandom_range(2, 255)), 1'b0);
      quiet_tail = 1'b1;
      run_random_phase(8'd40, 1'b0);

      repeat (TAIL_CYCLES) @(negedge clock);
      if (digit_expect.size() != 0)
         report_mismatch("digit beats never returned", 0, digit_expect.size());

      $display("Converted %0d values into %0d digit beats (%0d empty) over %0d capacity writes.",
               values_taken, beats_seen, empty_beats, capacity_writes);
      $display("Request side was held off for %0d cycles; %0d mismatches.",
               input_stalls, errors);
      if (errors == 0) begin
         $display("binary128_to_decimal_digits regression: pass");
      end else begin
         $display("binary128_to_decimal_digits regression: fail");
      end
      $finish;
   end

   initial begin
      #(15_000_000);
      $display("Timed out with %0d values pending and %0d digit beats outstanding.",
               value_pending.size(), digit_expect.size());
      $display("binary128_to_decimal_digits regression: fail");
      $finish;
   end

endmodule

// File: files.f
sv/b2d_pkg.sv
sv/b2d_front.sv
sv/b2d_back.sv
sv/binary128_to_decimal_digits.sv
test/tb_binary128_to_decimal_digits.sv
